>>> rtl/clcd_pkg.sv
package clcd_pkg;

   typedef enum logic [2:0] {
      FUNC_DATA  = 3'd0,
      FUNC_CMD   = 3'd1,
      FUNC_POS   = 3'd2,
      FUNC_NUM   = 3'd3,
      FUNC_INIT  = 3'd4,
      FUNC_CLEAR = 3'd5
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  char_code;
      logic [15:0] value;
      logic        row;
      logic [5:0]  col;
   } req_type;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [17:0] wait_before_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } seq_status_type;

   localparam int unsigned DIGIT_CAP = 7;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_RETURN_HOME  = 8'h02;
   localparam logic [3:0] NIB_WAKE         = 4'h3;
   localparam logic [3:0] NIB_4BIT         = 4'h2;
   localparam logic [7:0] CHAR_ZERO        = 8'h30;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;

   localparam logic [17:0] WAIT_POWER_UP = 18'd48000;
   localparam logic [17:0] WAIT_SECOND   = 18'd5000;
   localparam logic [17:0] WAIT_THIRD    = 18'd150000;
   localparam logic [17:0] WAIT_NONE     = 18'd0;

   localparam logic [15:0] ENABLE_HOLD_RESET = 16'd1200;

   localparam logic [3:0] LAST_BYTE  = 4'd1;
   localparam logic [3:0] LAST_PAIR  = 4'd3;
   localparam logic [3:0] LAST_INIT  = 4'd15;

   function automatic logic [3:0] init_nibble(input logic [3:0] step);
      logic [3:0] nib;
      case (step)
         4'd0, 4'd1, 4'd2: nib = NIB_WAKE;
         4'd3:  nib = NIB_4BIT;
         4'd4:  nib = CMD_FUNCTION_SET[7:4];
         4'd5:  nib = CMD_FUNCTION_SET[3:0];
         4'd6:  nib = CMD_DISPLAY_ON[7:4];
         4'd7:  nib = CMD_DISPLAY_ON[3:0];
         4'd8:  nib = CMD_CLEAR[7:4];
         4'd9:  nib = CMD_CLEAR[3:0];
         4'd10: nib = CMD_ENTRY_MODE[7:4];
         4'd11: nib = CMD_ENTRY_MODE[3:0];
         4'd12: nib = CMD_RETURN_HOME[7:4];
         4'd13: nib = CMD_RETURN_HOME[3:0];
         4'd14: nib = CMD_CLEAR[7:4];
         default: nib = CMD_CLEAR[3:0];
      endcase
      return nib;
   endfunction

   function automatic logic [17:0] init_wait(input logic [3:0] step);
      logic [17:0] w;
      case (step)
         4'd0: w = WAIT_POWER_UP;
         4'd1: w = WAIT_SECOND;
         4'd2: w = WAIT_THIRD;
         default: w = WAIT_NONE;
      endcase
      return w;
   endfunction

   function automatic logic [23:0] place_value(input logic [2:0] place);
      logic [23:0] pv;
      case (place)
         3'd0: pv = 24'd1;
         3'd1: pv = 24'd10;
         3'd2: pv = 24'd100;
         3'd3: pv = 24'd1000;
         3'd4: pv = 24'd10000;
         3'd5: pv = 24'd100000;
         3'd6: pv = 24'd1000000;
         default: pv = 24'd10000000;
      endcase
      return pv;
   endfunction

endpackage

>>> rtl/clcd_digit.sv
module clcd_digit (
   input  logic [15:0] rem,
   input  logic [2:0]  place,
   output logic [3:0]  digit,
   output logic [15:0] rem_next
);

   logic [23:0] step_val;
   logic [23:0] thr;
   logic [23:0] sub;

   always_comb begin
      step_val = clcd_pkg::place_value(place);
      digit    = 4'd0;
      sub      = 24'd0;
      thr      = 24'd0;
      for (int k = 1; k < 10; k++) begin
         thr = 24'(k) * step_val;
         if ({8'd0, rem} >= thr) begin
            digit = 4'(k);
            sub   = thr;
         end
      end
      rem_next = rem - sub[15:0];
   end

endmodule

>>> rtl/clcd_seq.sv
module clcd_seq #(
   parameter int unsigned NUM_DIGITS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  clcd_pkg::req_type          req,
   output logic                       req_ready,
   input  logic                       out_free,
   output clcd_pkg::rsp_type          item,
   output clcd_pkg::seq_status_type   status
);

   localparam int unsigned DIGITS = (NUM_DIGITS < 1) ? 1 :
      ((NUM_DIGITS > clcd_pkg::DIGIT_CAP) ? clcd_pkg::DIGIT_CAP : NUM_DIGITS);
   localparam logic [63:0] MODULUS   = 64'(10 ** DIGITS);
   localparam logic        REDUCE    = (MODULUS <= 64'd65535);
   localparam logic [63:0] RECIP     = (64'd1 << 32) / MODULUS;
   localparam logic [2:0]  PLACE_TOP = 3'(DIGITS - 1);
   localparam logic [3:0]  LAST_NUM  = 4'(2 * DIGITS + 1);

   logic                  active_ff, active_in;
   clcd_pkg::req_type     req_ff, req_in;
   logic [3:0]            step_ff, step_in;
   logic [15:0]           quot_ff, quot_in;
   logic [15:0]           rem_ff, rem_in;
   logic [2:0]            place_ff, place_in;
   logic [3:0]            digit_ff, digit_in;
   logic                  shown_ff, shown_in;

   logic                  valid_func;
   logic                  load;
   logic                  emit;
   logic                  hi_sel;
   logic [7:0]            addr;
   logic [3:0]            last_idx;
   logic [3:0]            digit_new;
   logic [15:0]           rem_next;
   logic                  shown_now;
   logic [47:0]           prod;
   logic [31:0]           back;
   logic [16:0]           diff;
   logic [15:0]           mod_val;

   clcd_digit u_digit (
      .rem      (rem_ff),
      .place    (place_ff),
      .digit    (digit_new),
      .rem_next (rem_next)
   );

   assign shown_now = shown_ff || (digit_new != 4'd0) || (place_ff == 3'd0);
   assign hi_sel    = !step_ff[0];
   assign addr      = {1'b1, req_ff.row, req_ff.col};

   always_comb begin
      item                = '0;
      last_idx            = clcd_pkg::LAST_BYTE;
      case (req_ff.func)
         clcd_pkg::FUNC_DATA: begin
            item.rs     = 1'b1;
            item.nibble = hi_sel ? req_ff.char_code[7:4] : req_ff.char_code[3:0];
         end
         clcd_pkg::FUNC_CMD: begin
            item.nibble = hi_sel ? req_ff.char_code[7:4] : req_ff.char_code[3:0];
         end
         clcd_pkg::FUNC_POS: begin
            last_idx = clcd_pkg::LAST_PAIR;
            if (step_ff < 4'd2) begin
               item.nibble = hi_sel ? addr[7:4] : addr[3:0];
            end else begin
               item.rs     = 1'b1;
               item.nibble = hi_sel ? req_ff.char_code[7:4] : req_ff.char_code[3:0];
            end
         end
         clcd_pkg::FUNC_NUM: begin
            last_idx = LAST_NUM;
            if (step_ff < 4'd2) begin
               item.nibble = hi_sel ? addr[7:4] : addr[3:0];
            end else if (hi_sel) begin
               item.rs     = 1'b1;
               item.nibble = shown_now ? clcd_pkg::CHAR_ZERO[7:4] : clcd_pkg::CHAR_SPACE[7:4];
            end else begin
               item.rs     = 1'b1;
               item.nibble = shown_ff ? digit_ff : clcd_pkg::CHAR_SPACE[3:0];
            end
         end
         clcd_pkg::FUNC_INIT: begin
            last_idx            = clcd_pkg::LAST_INIT;
            item.nibble         = clcd_pkg::init_nibble(step_ff);
            item.wait_before_us = clcd_pkg::init_wait(step_ff);
         end
         clcd_pkg::FUNC_CLEAR: begin
            last_idx = clcd_pkg::LAST_PAIR;
            if (step_ff[1]) begin
               item.nibble = hi_sel ? clcd_pkg::CMD_CLEAR[7:4] : clcd_pkg::CMD_CLEAR[3:0];
            end else begin
               item.nibble = hi_sel ? clcd_pkg::CMD_RETURN_HOME[7:4]
                                    : clcd_pkg::CMD_RETURN_HOME[3:0];
            end
         end
         default: begin
            last_idx = clcd_pkg::LAST_BYTE;
         end
      endcase
      item.last = (step_ff == last_idx);
   end

   always_comb begin
      valid_func = req.func inside {clcd_pkg::FUNC_DATA, clcd_pkg::FUNC_CMD,
                                    clcd_pkg::FUNC_POS, clcd_pkg::FUNC_NUM,
                                    clcd_pkg::FUNC_INIT, clcd_pkg::FUNC_CLEAR};
   end

   assign emit      = active_ff && out_free;
   assign req_ready = !active_ff || (out_free && item.last);
   assign load      = req_valid && req_ready && valid_func;

   assign status.busy = active_ff;
   assign status.emit = emit;

   always_comb begin
      prod = 48'(req_ff.value) * 48'(RECIP[31:0]);
      back = 32'(quot_ff) * 32'(MODULUS[15:0]);
      diff = 17'(req_ff.value) - back[16:0];
      if (diff >= MODULUS[16:0]) begin
         diff = diff - MODULUS[16:0];
      end
      mod_val = REDUCE ? diff[15:0] : req_ff.value;
   end

   always_comb begin
      active_in = active_ff;
      req_in    = req_ff;
      step_in   = step_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      place_in  = place_ff;
      digit_in  = digit_ff;
      shown_in  = shown_ff;
      if (emit) begin
         step_in = step_ff + 4'd1;
         if (item.last) begin
            active_in = 1'b0;
         end
         if (req_ff.func == clcd_pkg::FUNC_NUM) begin
            if (step_ff == 4'd0) begin
               quot_in = prod[47:32];
            end else if (step_ff == 4'd1) begin
               rem_in = mod_val;
            end else if (hi_sel) begin
               digit_in = digit_new;
               shown_in = shown_now;
               rem_in   = rem_next;
            end else begin
               place_in = place_ff - 3'd1;
            end
         end
      end
      if (load) begin
         active_in = 1'b1;
         req_in    = req;
         step_in   = 4'd0;
         place_in  = PLACE_TOP;
         shown_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      step_ff  <= step_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      place_ff <= place_in;
      digit_ff <= digit_in;
      shown_ff <= shown_in;
   end

endmodule

>>> rtl/char_lcd_4bit_nibble_sequencer_core.sv
// Channel  Ports                        Contents
// req      req_tvalid/tready/tdata/tuser one request: function and operands
// rsp      rsp_tvalid/tready/tdata/tuser one nibble transfer, tlast on the final one
//          /tlast
// csr      csr_valid/ready/wdata         enable hold time in microseconds
//
// A request causes these transfers: 2 for data, command;
// 4 for a positioned char or clear; 2 + 2*digits for a number; 16 for init.
// The step counter over the held request sets this; one transfer per cycle unless rsp stalls.
// The next request is taken in the cycle its predecessor's final transfer leaves.
// Reset clears the request and result valid flags; enable hold returns to 1200.
// A stalled rsp holds the result register and freezes the sequencer.
module char_lcd_4bit_nibble_sequencer_core #(
   parameter int unsigned NUM_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code[7:0], value[23:8], row[24], col[30:25]
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // nibble[3:0], wait_before_us[21:4]
   output logic        rsp_tuser,   // rs
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   clcd_pkg::req_type         req;
   clcd_pkg::rsp_type         item;
   clcd_pkg::seq_status_type  status;
   clcd_pkg::rsp_type         rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               enable_hold_ff, enable_hold_in;
   logic                      out_free;

   assign req.func      = clcd_pkg::func_type'(req_tuser);
   assign req.char_code = req_tdata[7:0];
   assign req.value     = req_tdata[23:8];
   assign req.row       = req_tdata[24];
   assign req.col       = req_tdata[30:25];

   assign out_free = !rsp_valid_ff || rsp_tready;

   clcd_seq #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .out_free  (out_free),
      .item      (item),
      .status    (status)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (status.emit) begin
         rsp_in       = item;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      enable_hold_in = enable_hold_ff;
      if (csr_valid && csr_ready) begin
         enable_hold_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         enable_hold_ff <= clcd_pkg::ENABLE_HOLD_RESET;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         enable_hold_ff <= enable_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.wait_before_us, rsp_ff.nibble};
   assign rsp_tuser  = rsp_ff.rs;
   assign rsp_tlast  = rsp_ff.last;

`ifndef SYNTHESIS
   a_last_lands : assert property (@(posedge clock) disable iff (reset)
      status.emit && item.last |=> rsp_tvalid && rsp_tlast)
      else $error("final transfer did not reach the result register");

   a_drop_unused : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser > 3'(clcd_pkg::FUNC_CLEAR)) |=> !status.busy)
      else $error("unused function code started a sequence");

   a_wait_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[21:4] != 18'd0) |-> !rsp_tuser)
      else $error("init wait on a data transfer");

   a_emit_busy : assert property (@(posedge clock) disable iff (reset)
      status.emit |-> status.busy && !(rsp_tvalid && !rsp_tready))
      else $error("transfer emitted into a full result register");
`endif

endmodule
